// ===== hw/rtl/vsls_pkg.sv =====
package vsls_pkg;

	// camera image width in pixels; error centre is FRAME_COLS/2
	localparam int unsigned FRAME_COLS = 640;

	localparam logic [15:0] RANGE_NONE = 16'hFFFF;
	localparam logic [15:0] AGE_MAX    = 16'hFFFF;

	// yaw datapath widths
	localparam int unsigned ERR_W     = 12;               // FRAME_COLS - 2*col
	localparam int unsigned NUM_W     = 25;               // gain * error, signed
	localparam int unsigned X_W       = 25;               // |num| + W/2
	localparam int unsigned DIV_SHIFT = X_W;
	localparam int unsigned RECIP     = (2 ** DIV_SHIFT) / FRAME_COLS;
	localparam int unsigned RECIP_W   = $clog2(RECIP + 1);
	localparam int unsigned PROD_W    = X_W + RECIP_W;
	localparam int unsigned Q_W       = RECIP_W;

	// speed datapath: Q8.8 gain
	localparam int unsigned SPD_FRAC = 8;

	// command queue between front and back
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [2:0] {
		OP_SAMPLE,
		OP_DETECT,
		OP_DIST,
		OP_TRACK,
		OP_TICK
	} op_t;

	typedef enum logic [2:0] {
		REG_YAW_GAIN,
		REG_DISTANCE_GAIN,
		REG_MAX_FORWARD_SPEED,
		REG_MAX_YAW_RATE,
		REG_STOP_RANGE,
		REG_CONE_HALF_ANGLE,
		REG_GOAL_RANGE,
		REG_TIMEOUT_TICKS
	} cfg_idx_t;

	typedef struct packed {
		logic [12:0] yaw_gain;
		logic [15:0] distance_gain;
		logic [11:0] max_forward_speed;
		logic [12:0] max_yaw_rate;
		logic [15:0] stop_range;
		logic [14:0] cone_half_angle;
		logic [15:0] goal_range;
		logic [15:0] timeout_ticks;
	} cfg_t;

	// one queued command from front to back
	typedef struct packed {
		logic        zero;   // zero command, stale or tracking exit
		logic [9:0]  col;
		logic        move;   // target beyond goal with known distance
		logic [15:0] diff;   // target_dist - goal_range
		logic        safe;   // obstacle inside stop range
	} cmd_t;

endpackage

// ===== hw/rtl/vsls_item_if.sv =====
interface vsls_item_if;
	logic              valid;
	logic              ready;
	logic [2:0]        op;
	logic signed [15:0] angle;
	logic [15:0]       range;
	logic [15:0]       range_lo;
	logic [15:0]       range_hi;
	logic              last_sample;
	logic [9:0]        target_column;
	logic [15:0]       distance;
	logic              distance_known;
	logic              tracking;

	modport source (
		output valid, op, angle, range, range_lo, range_hi, last_sample,
		output target_column, distance, distance_known, tracking,
		input  ready
	);
	modport sink (
		input  valid, op, angle, range, range_lo, range_hi, last_sample,
		input  target_column, distance, distance_known, tracking,
		output ready
	);
endinterface

// ===== hw/rtl/vsls_result_if.sv =====
interface vsls_result_if;
	logic               valid;
	logic               ready;
	logic signed [13:0] yaw_rate;
	logic [11:0]        forward_speed;
	logic               safety_stop;
	logic               stale_stop;

	modport source (
		output valid, yaw_rate, forward_speed, safety_stop, stale_stop,
		input  ready
	);
	modport sink (
		input  valid, yaw_rate, forward_speed, safety_stop, stale_stop,
		output ready
	);
endinterface

// ===== hw/rtl/visual_servo_with_lidar_stop.sv =====
// Proportional visual-servo controller with a lidar obstacle stop. One tagged
// word is taken per clock while the four-entry command queue has room: lidar
// samples, detections, distances and tracking events only update state, and a
// control tick while tracking (or leaving tracking) queues one command. Each
// command word is held on result_out until taken; with result_out.ready high the
// block sustains one word per cycle in and one command per cycle out. The back
// end's pipeline stages are products, rounding and speed limit, reciprocal
// multiply for the divide by the image width, quotient correction, then clamp
// and sign. Configuration registers may be rewritten only while no command is
// in flight.
module visual_servo_with_lidar_stop
	import vsls_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [2:0]    wr_index,
	input  logic [15:0]   wr_data,
	vsls_item_if.sink     item_in,
	vsls_result_if.source result_out
);

	cfg_t cfg_q;

	// front to queue
	logic push;
	cmd_t push_cmd;
	logic q_full;

	// queue to back
	logic head_valid;
	cmd_t head;
	logic pop;

	// config registers; truncated to each field's width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.yaw_gain          <= 13'd1000;
			cfg_q.distance_gain     <= 16'd128;
			cfg_q.max_forward_speed <= 12'd300;
			cfg_q.max_yaw_rate      <= 13'd500;
			cfg_q.stop_range        <= 16'd300;
			cfg_q.cone_half_angle   <= 15'd3000;
			cfg_q.goal_range        <= 16'd500;
			cfg_q.timeout_ticks     <= 16'd10;
		end else if (wr_en) begin
			case (cfg_idx_t'(wr_index))
				REG_YAW_GAIN:          cfg_q.yaw_gain          <= wr_data[12:0];
				REG_DISTANCE_GAIN:     cfg_q.distance_gain     <= wr_data;
				REG_MAX_FORWARD_SPEED: cfg_q.max_forward_speed <= wr_data[11:0];
				REG_MAX_YAW_RATE:      cfg_q.max_yaw_rate      <= wr_data[12:0];
				REG_STOP_RANGE:        cfg_q.stop_range        <= wr_data;
				REG_CONE_HALF_ANGLE:   cfg_q.cone_half_angle   <= wr_data[14:0];
				REG_GOAL_RANGE:        cfg_q.goal_range        <= wr_data;
				REG_TIMEOUT_TICKS:     cfg_q.timeout_ticks     <= wr_data;
				default: ;
			endcase
		end
	end

	// front: takes every word, keeps scan minimum and target state,
	// snapshots what a command needs
	vsls_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.item_in (item_in),
		.q_full  (q_full),
		.push    (push),
		.cmd     (push_cmd)
	);

	// decouples the front from output stalls
	vsls_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_cmd     (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// back: yaw and speed arithmetic, output register
	vsls_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.result_out (result_out)
	);

`ifndef SYNTH
	// front never queues a command the queue cannot hold
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("command pushed into full queue");

	// stale or exit command has zero yaw, zero speed and no safety stop
	a_stale_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid && result_out.stale_stop |->
			result_out.yaw_rate == '0 && result_out.forward_speed == '0
			&& !result_out.safety_stop)
		else $error("stale command not zero");

	// obstacle stop forces zero speed
	a_safety_speed: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid && result_out.safety_stop |-> result_out.forward_speed == '0)
		else $error("forward speed under safety stop");
`endif

endmodule

// ===== hw/rtl/vsls_front.sv =====
module vsls_front
	import vsls_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	vsls_item_if.sink   item_in,
	input  logic        q_full,
	output logic        push,
	output cmd_t        cmd
);

	logic        active_q;
	logic [9:0]  target_col_q;
	logic [15:0] detection_age_q;
	logic [15:0] target_dist_q;
	logic        target_dist_valid_q;
	logic [15:0] obstacle_range_q;
	logic [15:0] scan_min_q;

	logic               accept;
	logic signed [16:0] ang_ext;
	logic [16:0]        ang_mag;
	logic               hit;
	logic [15:0]        scan_min_next;
	logic [15:0]        age_next;

	assign item_in.ready = !q_full;
	assign accept        = item_in.valid && item_in.ready;

	// scan sample: cone, scan limits and running minimum
	assign ang_ext = {item_in.angle[15], item_in.angle};
	assign ang_mag = ang_ext[16] ? 17'(-ang_ext) : 17'(ang_ext);
	assign hit = (ang_mag <= {2'b00, cfg.cone_half_angle})
		&& (item_in.range >= item_in.range_lo)
		&& (item_in.range <= item_in.range_hi)
		&& (item_in.range != RANGE_NONE)
		&& (item_in.range < scan_min_q);
	assign scan_min_next = hit ? item_in.range : scan_min_q;

	assign age_next = (detection_age_q == AGE_MAX) ? detection_age_q
		: detection_age_q + 16'd1;

	always_comb begin
		push     = 1'b0;
		cmd.zero = 1'b0;
		cmd.col  = target_col_q;
		cmd.move = target_dist_valid_q && (target_dist_q > cfg.goal_range);
		cmd.diff = target_dist_q - cfg.goal_range;
		cmd.safe = obstacle_range_q < cfg.stop_range;
		if (accept) begin
			case (op_t'(item_in.op))
				OP_TRACK: begin
					if (!item_in.tracking && active_q) begin
						push     = 1'b1;
						cmd.zero = 1'b1;
					end
				end
				OP_TICK: begin
					if (active_q) begin
						push     = 1'b1;
						cmd.zero = age_next > cfg.timeout_ticks;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q            <= 1'b0;
			target_col_q        <= '0;
			detection_age_q     <= '0;
			target_dist_q       <= '0;
			target_dist_valid_q <= 1'b0;
			obstacle_range_q    <= RANGE_NONE;
			scan_min_q          <= RANGE_NONE;
		end else if (accept) begin
			case (op_t'(item_in.op))
				OP_SAMPLE: begin
					if (item_in.last_sample) begin
						obstacle_range_q <= scan_min_next;
						scan_min_q       <= RANGE_NONE;
					end else begin
						scan_min_q <= scan_min_next;
					end
				end
				OP_DETECT: begin
					if (active_q) begin
						target_col_q    <= item_in.target_column;
						detection_age_q <= '0;
					end
				end
				OP_DIST: begin
					if (active_q) begin
						target_dist_q       <= item_in.distance;
						target_dist_valid_q <= item_in.distance_known;
					end
				end
				OP_TRACK: begin
					if (item_in.tracking && !active_q) begin
						active_q            <= 1'b1;
						target_dist_valid_q <= 1'b0;
					end else if (!item_in.tracking && active_q) begin
						active_q <= 1'b0;
					end
				end
				OP_TICK: begin
					detection_age_q <= age_next;
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== hw/rtl/vsls_queue.sv =====
module vsls_queue
	import vsls_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wr_cmd,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full       = count_q == QCNT_W'(QDEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/vsls_back.sv =====
module vsls_back
	import vsls_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	input  logic          head_valid,
	input  cmd_t          head,
	output logic          pop,
	vsls_result_if.source result_out
);

	logic advance;

	logic v_s1, v_s2, v_s3, v_s4, res_valid_q;

	// s1: products
	logic signed [NUM_W-1:0] yaw_num_s1;
	logic [31:0]             spd_prod_s1;
	logic                    zero_s1, move_s1, safe_s1;
	// s2: rounded magnitude, limited speed
	logic [X_W-1:0]          x_s2;
	logic [11:0]             speed_s2;
	logic                    zero_s2, safe_s2, neg_s2;
	// s3: reciprocal product
	logic [PROD_W-1:0]       prod_s3;
	logic [X_W-1:0]          x_s3;
	logic [11:0]             speed_s3;
	logic                    zero_s3, safe_s3, neg_s3;
	// s4: quotient
	logic [Q_W-1:0]          q_s4;
	logic [11:0]             speed_s4;
	logic                    zero_s4, safe_s4, neg_s4;
	// output word
	logic signed [13:0]      yaw_rate_q;
	logic [11:0]             forward_speed_q;
	logic                    safety_stop_q, stale_stop_q;

	logic signed [ERR_W-1:0] err;
	logic signed [13:0]      gain_s;
	logic [X_W-1:0]          num_mag;
	logic [32:0]             spd_round;
	logic [24:0]             spd_v;
	logic [11:0]             spd_lim;
	logic [Q_W-1:0]          q0;
	logic [X_W-1:0]          q0_w;
	logic [X_W-1:0]          rem;
	logic [12:0]             yaw_mag;
	logic signed [13:0]      yaw_pos;

	assign advance = !res_valid_q || result_out.ready;
	assign pop     = advance && head_valid;

	assign err    = $signed(ERR_W'(FRAME_COLS)) - $signed(ERR_W'({head.col, 1'b0}));
	assign gain_s = $signed({1'b0, cfg.yaw_gain});

	assign num_mag   = yaw_num_s1[NUM_W-1] ? X_W'(-yaw_num_s1) : X_W'(yaw_num_s1);
	assign spd_round = 33'(spd_prod_s1) + 33'(1 << (SPD_FRAC - 1));
	assign spd_v     = spd_round[32:SPD_FRAC];
	assign spd_lim   = (spd_v > 25'(cfg.max_forward_speed)) ? cfg.max_forward_speed
		: spd_v[11:0];

	// reciprocal estimate is exact or one low; one compare fixes it
	assign q0   = prod_s3[PROD_W-1:DIV_SHIFT];
	assign q0_w = X_W'(X_W'(q0) * X_W'(FRAME_COLS));
	assign rem  = x_s3 - q0_w;

	assign yaw_mag = (32'(q_s4) > 32'(cfg.max_yaw_rate)) ? cfg.max_yaw_rate : q_s4[12:0];
	assign yaw_pos = $signed({1'b0, yaw_mag});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (advance) begin
			v_s1        <= head_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			res_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			yaw_num_s1  <= gain_s * err;
			spd_prod_s1 <= 32'(cfg.distance_gain) * 32'(head.diff);
			zero_s1     <= head.zero;
			move_s1     <= head.move;
			safe_s1     <= head.safe;

			x_s2     <= num_mag + X_W'(FRAME_COLS / 2);
			speed_s2 <= (move_s1 && !safe_s1) ? spd_lim : '0;
			zero_s2  <= zero_s1;
			safe_s2  <= safe_s1;
			neg_s2   <= yaw_num_s1[NUM_W-1];

			prod_s3  <= PROD_W'(x_s2) * PROD_W'(RECIP);
			x_s3     <= x_s2;
			speed_s3 <= speed_s2;
			zero_s3  <= zero_s2;
			safe_s3  <= safe_s2;
			neg_s3   <= neg_s2;

			q_s4     <= (rem >= X_W'(FRAME_COLS)) ? q0 + 1'b1 : q0;
			speed_s4 <= speed_s3;
			zero_s4  <= zero_s3;
			safe_s4  <= safe_s3;
			neg_s4   <= neg_s3;

			if (zero_s4) begin
				yaw_rate_q      <= '0;
				forward_speed_q <= '0;
				safety_stop_q   <= 1'b0;
				stale_stop_q    <= 1'b1;
			end else begin
				yaw_rate_q      <= neg_s4 ? -yaw_pos : yaw_pos;
				forward_speed_q <= speed_s4;
				safety_stop_q   <= safe_s4;
				stale_stop_q    <= 1'b0;
			end
		end
	end

	assign result_out.valid         = res_valid_q;
	assign result_out.yaw_rate      = yaw_rate_q;
	assign result_out.forward_speed = forward_speed_q;
	assign result_out.safety_stop   = safety_stop_q;
	assign result_out.stale_stop    = stale_stop_q;

endmodule

// ===== test/visual_servo_with_lidar_stop_tb.sv =====
module visual_servo_with_lidar_stop_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import vsls_pkg::*;

	localparam int CYCLE_LIMIT     = 250000;  // watchdog, far above the slowest run
	localparam int HOLD_LEN        = 300;     // long receiver stall, fills the command queue
	localparam int SETTLE_CYCLES   = 8;       // back end is five deep, plus margin
	localparam int WORDS_PER_PHASE = 310;
	localparam int REPORT_MAX      = 10;

	// op codes outside the defined set, must be swallowed
	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	// one input word, field for field as on item_in
	typedef struct packed {
		logic [2:0]         op;
		logic signed [15:0] angle;
		logic [15:0]        range;
		logic [15:0]        range_lo;
		logic [15:0]        range_hi;
		logic               last_sample;
		logic [9:0]         target_column;
		logic [15:0]        distance;
		logic               distance_known;
		logic               tracking;
	} servo_word_t;

	// one command word as on result_out
	typedef struct packed {
		logic signed [13:0] yaw;
		logic [11:0]        speed;
		logic               safe;
		logic               stale;
	} servo_cmd_t;

	localparam servo_cmd_t NO_CMD = '0;

	// directed table row: word, repeat count, optional hand-written command
	typedef struct {
		servo_word_t w;
		int          reps;
		bit          typed;
		servo_cmd_t  c;
	} script_row_t;

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	logic [2:0]  wr_index;
	logic [15:0] wr_data;

	vsls_item_if   item_bus ();
	vsls_result_if res_bus ();

	visual_servo_with_lidar_stop u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.item_in   (item_bus),
		.result_out(res_bus)
	);

	// ---------------------------------------------------------------
	// predictor state: our own copy of the settings and of the block
	// ---------------------------------------------------------------
	cfg_t        cfg;
	bit          following;    // tracking mode
	logic [9:0]  aim_col;      // last detected column
	logic [15:0] since_seen;   // ticks since the last detection, saturating
	logic [15:0] aim_dist;
	bit          aim_dist_ok;
	logic [15:0] near_obst;    // committed in-cone minimum of the last scan
	logic [15:0] scan_low;     // running minimum of the scan in progress

	servo_cmd_t  due_cmds[$];  // commands predicted, not yet seen
	script_row_t script[$];

	int mism;
	int words_in;
	int cmds_seen;
	int safety_seen;
	int stale_seen;
	int cycles;
	int src_idle_pct;
	int sink_idle_pct;
	int hold_ticket;   // bumped by the stimulus to ask for a long stall
	int hold_taken;
	int hold_left;

	// clock, 8 ns
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Works out the command (if any) that one word causes and moves the
	// predictor state on. Returns 1 when a command is due.
	function automatic bit predict_command(input servo_word_t w, output servo_cmd_t c);
		int     mag;
		longint num;
		longint yaw;
		longint lim;
		longint spd;
		longint wid;
		c = '0;
		wid = FRAME_COLS;
		case (w.op)
			OP_SAMPLE: begin
				mag = (w.angle < 0) ? -int'(w.angle) : int'(w.angle);
				if (mag <= int'(cfg.cone_half_angle) && w.range >= w.range_lo &&
						w.range <= w.range_hi && w.range != RANGE_NONE && w.range < scan_low)
					scan_low = w.range;
				// end of scan: commit and restart the minimum
				if (w.last_sample) begin
					near_obst = scan_low;
					scan_low = RANGE_NONE;
				end
			end
			OP_DETECT: begin
				if (following) begin
					aim_col = w.target_column;
					since_seen = '0;
				end
			end
			OP_DIST: begin
				if (following) begin
					aim_dist = w.distance;
					aim_dist_ok = w.distance_known;
				end
			end
			OP_TRACK: begin
				if (w.tracking && !following) begin
					following = 1'b1;
					aim_dist_ok = 1'b0;
				end else if (!w.tracking && following) begin
					// leaving tracking: one zero command
					following = 1'b0;
					c.stale = 1'b1;
					return 1'b1;
				end
			end
			OP_TICK: begin
				if (since_seen != AGE_MAX)
					since_seen++;
				if (!following)
					return 1'b0;
				if (since_seen > cfg.timeout_ticks) begin
					c.stale = 1'b1;
					return 1'b1;
				end
				// yaw: gain * (W - 2 col) / W, rounded half away from zero
				num = longint'(cfg.yaw_gain) * (wid - 2 * longint'(aim_col));
				yaw = (num >= 0) ? (num + wid / 2) / wid : -((-num + wid / 2) / wid);
				lim = longint'(cfg.max_yaw_rate);
				if (yaw > lim)
					yaw = lim;
				else if (yaw < -lim)
					yaw = -lim;
				// speed: Q8.8 gain on the excess over the goal
				spd = 0;
				if (aim_dist_ok && aim_dist > cfg.goal_range) begin
					spd = (longint'(cfg.distance_gain) *
						(longint'(aim_dist) - longint'(cfg.goal_range)) + 128) >>> 8;
					if (spd > longint'(cfg.max_forward_speed))
						spd = longint'(cfg.max_forward_speed);
				end
				if (near_obst < cfg.stop_range) begin
					spd = 0;
					c.safe = 1'b1;
				end
				c.yaw = yaw[13:0];
				c.speed = spd[11:0];
				return 1'b1;
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	function automatic logic [15:0] clip16(input int v);
		if (v < 0)
			return '0;
		if (v > 65535)
			return 16'hFFFF;
		return 16'(v);
	endfunction

	// random fill for every field; op within the defined set
	function automatic servo_word_t any_word();
		servo_word_t w;
		w.op = 3'($urandom_range(0, 4));
		w.angle = 16'(int'($urandom_range(0, 36000)) - 18000);
		w.range = 16'($urandom);
		w.range_lo = 16'($urandom);
		w.range_hi = 16'($urandom_range(0, 65534));
		w.last_sample = 1'($urandom);
		w.target_column = 10'($urandom);
		w.distance = 16'($urandom);
		w.distance_known = 1'($urandom);
		w.tracking = 1'($urandom);
		return w;
	endfunction

	// word builders: only the fields the op reads are fixed, the rest is noise
	function automatic servo_word_t w_scan(input int ang, input int rng, input int lo,
			input int hi, input bit last);
		servo_word_t w;
		w = any_word();
		w.op = OP_SAMPLE;
		w.angle = 16'(ang);
		w.range = 16'(rng);
		w.range_lo = 16'(lo);
		w.range_hi = 16'(hi);
		w.last_sample = last;
		return w;
	endfunction

	function automatic servo_word_t w_detect(input int col);
		servo_word_t w;
		w = any_word();
		w.op = OP_DETECT;
		w.target_column = 10'(col);
		return w;
	endfunction

	function automatic servo_word_t w_dist(input int d, input bit known);
		servo_word_t w;
		w = any_word();
		w.op = OP_DIST;
		w.distance = 16'(d);
		w.distance_known = known;
		return w;
	endfunction

	function automatic servo_word_t w_track(input bit on);
		servo_word_t w;
		w = any_word();
		w.op = OP_TRACK;
		w.tracking = on;
		return w;
	endfunction

	function automatic servo_word_t w_op(input logic [2:0] op);
		servo_word_t w;
		w = any_word();
		w.op = op;
		return w;
	endfunction

	function automatic servo_cmd_t cmd_of(input int yaw, input int spd, input bit safe,
			input bit stale);
		servo_cmd_t c;
		c.yaw = 14'(yaw);
		c.speed = 12'(spd);
		c.safe = safe;
		c.stale = stale;
		return c;
	endfunction

	function automatic void add_row(input servo_word_t w, input int reps, input bit typed,
			input servo_cmd_t c);
		script_row_t r;
		r.w = w;
		r.reps = reps;
		r.typed = typed;
		r.c = c;
		script.push_back(r);
	endfunction

	// Offers one word from the falling edge, with random gaps, and waits for
	// the handshake. A hand-written command, where given, replaces the
	// predicted one; the predictor still runs to keep its state.
	task automatic push_word(input servo_word_t w, input bit typed, input servo_cmd_t typed_cmd);
		servo_cmd_t c;
		bit         counts;
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			item_bus.valid <= 1'b0;
			@(negedge clk);
		end
		item_bus.op             <= w.op;
		item_bus.angle          <= w.angle;
		item_bus.range          <= w.range;
		item_bus.range_lo       <= w.range_lo;
		item_bus.range_hi       <= w.range_hi;
		item_bus.last_sample    <= w.last_sample;
		item_bus.target_column  <= w.target_column;
		item_bus.distance       <= w.distance;
		item_bus.distance_known <= w.distance_known;
		item_bus.tracking       <= w.tracking;
		item_bus.valid          <= 1'b1;
		@(posedge clk);
		while (!item_bus.ready)
			@(posedge clk);
		// words the block merely drops are not counted
		counts = (w.op == OP_SAMPLE) || (w.op == OP_TICK) ||
			(following && (w.op == OP_DETECT || w.op == OP_DIST)) ||
			(w.op == OP_TRACK && w.tracking != following);
		if (predict_command(w, c))
			due_cmds.push_back(typed ? typed_cmd : c);
		if (counts)
			words_in++;
	endtask

	task automatic push(input servo_word_t w);
		push_word(w, 1'b0, NO_CMD);
	endtask

	// sender stops, every command drains, then the back end gets time to empty
	task automatic await_idle();
		@(negedge clk);
		item_bus.valid <= 1'b0;
		while (due_cmds.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [15:0] v);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= v;
		@(negedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_YAW_GAIN:          cfg.yaw_gain = v[12:0];
			REG_DISTANCE_GAIN:     cfg.distance_gain = v;
			REG_MAX_FORWARD_SPEED: cfg.max_forward_speed = v[11:0];
			REG_MAX_YAW_RATE:      cfg.max_yaw_rate = v[12:0];
			REG_STOP_RANGE:        cfg.stop_range = v;
			REG_CONE_HALF_ANGLE:   cfg.cone_half_angle = v[14:0];
			REG_GOAL_RANGE:        cfg.goal_range = v;
			REG_TIMEOUT_TICKS:     cfg.timeout_ticks = v;
			default: ;
		endcase
	endtask

	task automatic apply_settings(input int yg, input int dg, input int mfs, input int myr,
			input int sd, input int cha, input int gd, input int tt);
		write_reg(REG_YAW_GAIN, 16'(yg));
		write_reg(REG_DISTANCE_GAIN, 16'(dg));
		write_reg(REG_MAX_FORWARD_SPEED, 16'(mfs));
		write_reg(REG_MAX_YAW_RATE, 16'(myr));
		write_reg(REG_STOP_RANGE, 16'(sd));
		write_reg(REG_CONE_HALF_ANGLE, 16'(cha));
		write_reg(REG_GOAL_RANGE, 16'(gd));
		write_reg(REG_TIMEOUT_TICKS, 16'(tt));
	endtask

	// Random traffic, mostly well-formed: scans closed by a last mark with
	// one band per scan, detections, distances near the goal and ticks while
	// tracking. A few words are pure noise, broken scans or spare ops.
	task automatic run_traffic(input int n);
		int          stop_at;
		int          roll;
		int          lo;
		int          hi;
		int          len;
		int          cone;
		int          k;
		bit          broken;
		servo_word_t w;
		stop_at = words_in + n;
		while (words_in < stop_at) begin
			if (!following && $urandom_range(0, 2) == 0)
				push(w_track(1'b1));
			roll = $urandom_range(0, 99);
			if (roll < 5) begin
				w = any_word();
				if (roll == 0)
					w.op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
				push(w);
			end else if (roll < 9) begin
				push(w_track(1'($urandom)));
			end else if (roll < 35) begin
				lo = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 65535)) :
					int'($urandom_range(0, 300));
				hi = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 65534)) :
					int'($urandom_range(1500, 65534));
				len = $urandom_range(1, 10);
				broken = ($urandom_range(0, 9) == 0);   // scan with no last mark
				cone = int'(cfg.cone_half_angle);
				for (k = 0; k < len; k++) begin
					w = any_word();
					w.op = OP_SAMPLE;
					w.range_lo = 16'(lo);
					w.range_hi = 16'(hi);
					if ($urandom_range(0, 1) == 0)
						w.angle = 16'(int'($urandom_range(0, 2 * cone)) - cone);
					case ($urandom_range(0, 5))
						0: w.range = 16'($urandom);
						1: w.range = clip16(int'(cfg.stop_range) +
							int'($urandom_range(0, 100)) - 50);
						2: w.range = RANGE_NONE;
						3: w.range = 16'(lo);
						4: w.range = 16'(hi);
						default: w.range = 16'($urandom_range(0, 2000));
					endcase
					w.last_sample = (k == len - 1) && !broken;
					push(w);
				end
			end else if (roll < 55) begin
				push(w_detect(($urandom_range(0, 2) == 0) ? int'($urandom_range(280, 360)) :
					int'($urandom_range(0, 1023))));
			end else if (roll < 65) begin
				w = w_dist(int'(clip16(int'(cfg.goal_range) +
					int'($urandom_range(0, 3000)) - 1000)), $urandom_range(0, 6) != 0);
				if ($urandom_range(0, 4) == 0)
					w.distance = 16'($urandom);
				push(w);
			end else begin
				push(w_op(OP_TICK));
			end
		end
	endtask

	// ---------------------------------------------------------------
	// receiver: random stalls, plus a long hold-off on request
	// ---------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_ticket != hold_taken) begin
			hold_taken = hold_ticket;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_bus.ready <= 1'b0;
		end else begin
			res_bus.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
		end
	end

	// checker: each command word taken against the oldest prediction
	always @(posedge clk) begin : check_cmds
		servo_cmd_t e;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			cmds_seen++;
			if (res_bus.safety_stop)
				safety_seen++;
			if (res_bus.stale_stop)
				stale_seen++;
			if (due_cmds.size() == 0) begin
				mism++;
				if (mism <= REPORT_MAX)
					$display("command %0d not expected: yaw %0d speed %0d safety %0b stale %0b",
						cmds_seen, res_bus.yaw_rate, res_bus.forward_speed,
						res_bus.safety_stop, res_bus.stale_stop);
			end else begin
				e = due_cmds.pop_front();
				if (res_bus.yaw_rate !== e.yaw || res_bus.forward_speed !== e.speed ||
						res_bus.safety_stop !== e.safe || res_bus.stale_stop !== e.stale) begin
					mism++;
					if (mism <= REPORT_MAX)
						$display("command %0d: expected %0d/%0d/%0b/%0b, got %0d/%0d/%0b/%0b",
							cmds_seen, e.yaw, e.speed, e.safe, e.stale, res_bus.yaw_rate,
							res_bus.forward_speed, res_bus.safety_stop, res_bus.stale_stop);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d commands outstanding", cycles, due_cmds.size());
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin : stimulus
		int p;
		int i;
		int k;

		// every input known from time zero
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		item_bus.valid = 1'b0;
		item_bus.op = '0;
		item_bus.angle = '0;
		item_bus.range = '0;
		item_bus.range_lo = '0;
		item_bus.range_hi = '0;
		item_bus.last_sample = 1'b0;
		item_bus.target_column = '0;
		item_bus.distance = '0;
		item_bus.distance_known = 1'b0;
		item_bus.tracking = 1'b0;
		res_bus.ready = 1'b0;
		mism = 0;
		words_in = 0;
		cmds_seen = 0;
		safety_seen = 0;
		stale_seen = 0;
		cycles = 0;
		hold_ticket = 0;
		hold_taken = 0;
		hold_left = 0;
		src_idle_pct = 17;
		sink_idle_pct = 79;

		// settings and state after reset
		cfg.yaw_gain = 13'd1000;
		cfg.distance_gain = 16'd128;
		cfg.max_forward_speed = 12'd300;
		cfg.max_yaw_rate = 13'd500;
		cfg.stop_range = 16'd300;
		cfg.cone_half_angle = 15'd3000;
		cfg.goal_range = 16'd500;
		cfg.timeout_ticks = 16'd10;
		following = 1'b0;
		aim_col = '0;
		since_seen = '0;
		aim_dist = '0;
		aim_dist_ok = 1'b0;
		near_obst = RANGE_NONE;
		scan_low = RANGE_NONE;

		// Directed table, reset settings. Hand-written commands only where
		// they follow from clamps alone; the rest go through the predictor.
		//      word                                  reps typed command
		add_row(w_op(OP_TICK),                         1, 0, NO_CMD);  // tick while idle: nothing
		add_row(w_detect(500),                         1, 0, NO_CMD);  // detection ignored when idle
		add_row(w_track(1'b0),                         1, 0, NO_CMD);  // same mode again: nothing
		add_row(w_track(1'b1),                         1, 0, NO_CMD);  // start tracking
		add_row(w_detect(0),                           1, 0, NO_CMD);  // left edge
		add_row(w_op(OP_TICK),                         1, 1, cmd_of(500, 0, 0, 0));
		add_row(w_detect(1023),                        1, 0, NO_CMD);  // far right edge
		add_row(w_dist(65535, 1'b1),                   1, 0, NO_CMD);
		add_row(w_op(OP_TICK),                         1, 1, cmd_of(-500, 300, 0, 0));
		add_row(w_scan(-18000, 100, 0, 65534, 1'b0),   1, 0, NO_CMD);  // outside the cone
		add_row(w_scan(18000, 65535, 0, 65534, 1'b0),  1, 0, NO_CMD);  // no return
		add_row(w_scan(3000, 250, 0, 65534, 1'b1),     1, 0, NO_CMD);  // cone edge, too near
		add_row(w_op(OP_TICK),                         1, 1, cmd_of(-500, 0, 1, 0));
		add_row(w_scan(-3000, 5000, 6000, 65534, 1'b1), 1, 0, NO_CMD); // below band: clears
		add_row(w_detect(316),                         1, 0, NO_CMD);  // yaw rounds up from .5
		add_row(w_dist(1000, 1'b1),                    1, 0, NO_CMD);
		add_row(w_op(OP_TICK),                         1, 0, NO_CMD);
		add_row(w_detect(324),                         1, 0, NO_CMD);  // and down from -.5
		add_row(w_dist(1200, 1'b0),                    1, 0, NO_CMD);  // unknown distance
		add_row(w_op(OP_TICK),                         1, 0, NO_CMD);
		add_row(w_scan(0, 0, 0, 0, 1'b1),              1, 0, NO_CMD);  // zero range, band of one
		add_row(w_op(OP_TICK),                        12, 0, NO_CMD);  // runs into stale
		add_row(w_op(OP_SPARE_LO),                     1, 0, NO_CMD);
		add_row(w_op(OP_SPARE_HI),                     1, 0, NO_CMD);
		add_row(w_track(1'b0),                         1, 1, cmd_of(0, 0, 0, 1));

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < script.size(); i++)
			for (k = 0; k < script[i].reps; k++)
				push_word(script[i].w, script[i].typed, script[i].c);

		for (p = 0; p < 6; p++) begin
			// new settings only with nothing in flight
			if (p > 0)
				await_idle();
			case (p)
				1: apply_settings(8000, 65535, 4000, 8000, 65535, 18000, 0, 65535);
				2: apply_settings(0, 0, 0, 0, 0, 0, 0, 0);
				3: apply_settings($urandom_range(0, 8000), 65535, $urandom_range(0, 4000),
					$urandom_range(0, 8000), 0, 0, 65535, 65535);
				4, 5: apply_settings($urandom_range(0, 8000), $urandom_range(0, 1024),
					$urandom_range(0, 4000), $urandom_range(0, 8000), $urandom_range(0, 2000),
					$urandom_range(0, 18000), $urandom_range(0, 3000), $urandom_range(0, 30));
				default: ;
			endcase
			// idling: slow receiver, then slow sender, then none
			if (p < 2) begin
				src_idle_pct = 17;
				sink_idle_pct = 79;
			end else if (p < 4) begin
				src_idle_pct = 79;
				sink_idle_pct = 17;
			end else begin
				src_idle_pct = 0;
				sink_idle_pct = 0;
			end
			if (p == 0) begin
				// back-pressure: receiver holds off while ticks keep coming,
				// so the queue fills and item_in stalls; then the sender
				// waits for every command to drain
				push(w_track(1'b1));
				push(w_detect(200));
				hold_ticket++;
				repeat (40) push(w_op(OP_TICK));
				await_idle();
			end
			run_traffic(WORDS_PER_PHASE);
		end

		await_idle();
		if (due_cmds.size() != 0) begin
			mism += due_cmds.size();
			$display("%0d predicted commands never arrived", due_cmds.size());
		end
		$display("%0d words driven through six settings and three idling patterns", words_in);
		$display("%0d commands checked: %0d safety stops, %0d stale or exit stops",
			cmds_seen, safety_seen, stale_seen);
		if (mism == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
